/* src/ewa_pkg.sv */
// Package with the types, codes and lattice constants of the exclusion walker aggregation block.
`timescale 1ns / 1ps

package ewa_pkg;

   // Lattice geometry.
   localparam int HALF_SIDE = 256;
   localparam int SIDE      = 2 * HALF_SIDE;
   localparam int ADDR_W    = $clog2(SIDE * SIDE);

   // Fixed field widths.
   localparam int COORD_W = 9;
   localparam int NCRD_W  = COORD_W + 1;
   localparam int WORD_W  = 16;
   localparam int THR_W   = 17;
   localparam int CELL_W  = 2;
   localparam int IDX_W   = 2;

   typedef enum logic [CELL_W-1:0] {
      CELL_EMPTY = 2'd0,
      CELL_GHOST = 2'd1,
      CELL_LIVE  = 2'd2,
      CELL_AGG   = 2'd3
   } cell_type;

   typedef enum logic [2:0] {
      OUT_NONE     = 3'd0,
      OUT_REVEALED = 3'd1,
      OUT_MOVED    = 3'd2,
      OUT_STUCK    = 3'd3,
      OUT_BORDER   = 3'd4,
      OUT_IGNORED  = 3'd5
   } outcome_type;

   typedef enum logic [1:0] {
      DIR_EAST  = 2'd0,
      DIR_NORTH = 2'd1,
      DIR_WEST  = 2'd2,
      DIR_SOUTH = 2'd3
   } dir_type;

   typedef enum logic [IDX_W-1:0] {
      REG_ALIVE     = 2'd0,
      REG_CONTAGION = 2'd1,
      REG_GHOST     = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_RD_SITE,
      ST_RD_NBR,
      ST_DECIDE,
      ST_WR_NBR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] site_x;
      logic [COORD_W-1:0] site_y;
      logic [1:0]         direction;
      logic [WORD_W-1:0]  rand_reveal_site;
      logic [WORD_W-1:0]  rand_fill_site;
      logic [WORD_W-1:0]  rand_reveal_nbr;
      logic [WORD_W-1:0]  rand_fill_nbr;
      logic [WORD_W-1:0]  rand_move;
   } item_type;

   typedef struct packed {
      logic [THR_W-1:0] alive_thr;
      logic [THR_W-1:0] contagion_thr;
      logic             ghost_mode;
   } cfg_type;

   typedef struct packed {
      outcome_type outcome;
      logic        run_over;
   } res_type;

   // Inputs of the update decision: the two cells and whether each lies on the lattice border.
   typedef struct packed {
      cell_type cs;
      cell_type cn;
      logic     site_border;
      logic     nbr_border;
   } dec_in_type;

   typedef struct packed {
      logic        wr_site;
      cell_type    site_val;
      logic        wr_nbr;
      cell_type    nbr_val;
      outcome_type outcome;
      logic        set_finished;
   } dec_out_type;

   // Bernoulli draw: true when the random word lies below the threshold.
   function automatic logic draw(input logic [WORD_W-1:0] word, input logic [THR_W-1:0] thr);
      return {1'b0, word} < thr;
   endfunction

endpackage

/* src/exclusion_walker_aggregation_step_top.sv */
// Top level of the exclusion walker aggregation block: ports, registers and result buffer.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  req_tdata, req_tuser
// rsp      out        rsp_tvalid / rsp_tready  rsp_tdata
// csr      in         csr_valid / csr_ready    csr_index, csr_data
//
// An update word sends the site read, the neighbor read and up to two write-backs one after
// another through the single lattice RAM port, and exits early when the run is over or the site
// or neighbor is off the lattice; a new word is accepted once its result has left the sequencer.
// Reset clears the sequencer and the run-over flag and sets the registers to their defaults;
// the lattice holds no reset value and must be initialized by init words.
// A result waits in the output register while the next word is already being worked on.

module exclusion_walker_aggregation_step_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // site_x[8:0], site_y[17:9], direction[19:18], rand_reveal_site[35:20],
   // rand_fill_site[51:36], rand_reveal_nbr[67:52], rand_fill_nbr[83:68],
   // rand_move[99:84], zero fill [103:100]
   input  logic [103:0]               req_tdata,
   // mode[0]
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // outcome[2:0], run_over[3], zero fill [7:4]
   output logic [7:0]                 rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ewa_pkg::IDX_W-1:0]  csr_index,
   input  logic [ewa_pkg::THR_W-1:0]  csr_data
);

   ewa_pkg::cfg_type  cfg_ff, cfg_in;
   ewa_pkg::item_type req_item;
   ewa_pkg::res_type  res;
   ewa_pkg::res_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              res_valid;
   logic              res_ready;

   always_comb begin
      req_item.mode             = req_tuser;
      req_item.site_x           = req_tdata[8:0];
      req_item.site_y           = req_tdata[17:9];
      req_item.direction        = req_tdata[19:18];
      req_item.rand_reveal_site = req_tdata[35:20];
      req_item.rand_fill_site   = req_tdata[51:36];
      req_item.rand_reveal_nbr  = req_tdata[67:52];
      req_item.rand_fill_nbr    = req_tdata[83:68];
      req_item.rand_move        = req_tdata[99:84];
   end

   ewa_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_item (req_item),
      .req_ready(req_tready),
      .cfg      (cfg_ff),
      .res_valid(res_valid),
      .res      (res),
      .res_ready(res_ready)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ewa_pkg::reg_index_type'(csr_index))
            ewa_pkg::REG_ALIVE:     cfg_in.alive_thr     = csr_data;
            ewa_pkg::REG_CONTAGION: cfg_in.contagion_thr = csr_data;
            ewa_pkg::REG_GHOST:     cfg_in.ghost_mode    = csr_data[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   // The output register frees itself in the same cycle that the sink takes its word.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alive_thr     <= ewa_pkg::THR_W'(32768);
         cfg_ff.contagion_thr <= ewa_pkg::THR_W'(65536);
         cfg_ff.ghost_mode    <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.run_over, rsp_ff.outcome};

endmodule

/* src/ewa_ram.sv */
// Single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module ewa_ram #(
   parameter int ADDR_W = 18,
   parameter int DATA_W = 2
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/ewa_decide.sv */
// Update decision: reveals, walker moves and sticking for one site and its neighbor.
`timescale 1ns / 1ps

module ewa_decide (
   input  ewa_pkg::item_type    item,
   input  ewa_pkg::cfg_type     cfg,
   input  ewa_pkg::dec_in_type  din,
   output ewa_pkg::dec_out_type dout
);

   always_comb begin
      ewa_pkg::cell_type cs1;
      ewa_pkg::cell_type cn1;
      ewa_pkg::cell_type cw;
      ewa_pkg::cell_type co;
      logic flag;
      logic stop;
      logic hit;
      logic site_walk;
      logic w_border;

      dout              = '0;
      dout.site_val     = ewa_pkg::CELL_EMPTY;
      dout.nbr_val      = ewa_pkg::CELL_EMPTY;
      dout.outcome      = ewa_pkg::OUT_NONE;
      cs1               = din.cs;
      cn1               = din.cn;
      flag              = 1'b0;
      stop              = (din.cs == din.cn);
      hit               = 1'b0;

      if (!stop && din.cs == ewa_pkg::CELL_GHOST) begin
         if (ewa_pkg::draw(item.rand_reveal_site, cfg.contagion_thr) ||
             din.cn == ewa_pkg::CELL_AGG) begin
            flag          = 1'b1;
            cs1           = ewa_pkg::draw(item.rand_fill_site, cfg.alive_thr) ?
                            ewa_pkg::CELL_LIVE : ewa_pkg::CELL_EMPTY;
            dout.wr_site  = 1'b1;
            dout.site_val = cs1;
         end else begin
            stop = 1'b1;
         end
      end

      if (!stop && din.cn == ewa_pkg::CELL_GHOST) begin
         if (ewa_pkg::draw(item.rand_reveal_nbr, cfg.contagion_thr) ||
             cs1 == ewa_pkg::CELL_AGG) begin
            flag         = 1'b1;
            cn1          = ewa_pkg::draw(item.rand_fill_nbr, cfg.alive_thr) ?
                           ewa_pkg::CELL_LIVE : ewa_pkg::CELL_EMPTY;
            dout.wr_nbr  = 1'b1;
            dout.nbr_val = cn1;
         end else begin
            stop = 1'b1;
         end
      end

      // The walker is the site if the site is live, otherwise the neighbor.
      site_walk = (cs1 == ewa_pkg::CELL_LIVE);
      cw        = site_walk ? cs1 : cn1;
      co        = site_walk ? cn1 : cs1;
      w_border  = site_walk ? din.site_border : din.nbr_border;

      if (!stop && cs1 != cn1 && cw == ewa_pkg::CELL_LIVE) begin
         if (co == ewa_pkg::CELL_EMPTY &&
             (ewa_pkg::draw(item.rand_move, cfg.contagion_thr) || flag)) begin
            hit           = 1'b1;
            dout.wr_site  = 1'b1;
            dout.wr_nbr   = 1'b1;
            dout.site_val = site_walk ? ewa_pkg::CELL_EMPTY : ewa_pkg::CELL_LIVE;
            dout.nbr_val  = site_walk ? ewa_pkg::CELL_LIVE : ewa_pkg::CELL_EMPTY;
            dout.outcome  = ewa_pkg::OUT_MOVED;
         end else if (co == ewa_pkg::CELL_AGG) begin
            hit               = 1'b1;
            dout.set_finished = w_border;
            dout.outcome      = w_border ? ewa_pkg::OUT_BORDER : ewa_pkg::OUT_STUCK;
            if (site_walk) begin
               dout.wr_site  = 1'b1;
               dout.site_val = ewa_pkg::CELL_AGG;
            end else begin
               dout.wr_nbr  = 1'b1;
               dout.nbr_val = ewa_pkg::CELL_AGG;
            end
         end
      end

      if (!hit) begin
         dout.outcome = flag ? ewa_pkg::OUT_REVEALED : ewa_pkg::OUT_NONE;
      end
   end

endmodule

/* src/ewa_engine.sv */
// Sequencer that reads, decides and writes back lattice cells for one word at a time.
`timescale 1ns / 1ps

module ewa_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  ewa_pkg::item_type req_item,
   output logic              req_ready,
   input  ewa_pkg::cfg_type  cfg,
   output logic              res_valid,
   output ewa_pkg::res_type  res,
   input  logic              res_ready
);

   ewa_pkg::state_type   state_ff, state_in;
   ewa_pkg::item_type    item_ff, item_in;
   ewa_pkg::cell_type    cs_ff, cs_in;
   ewa_pkg::cell_type    nbr_val_ff, nbr_val_in;
   ewa_pkg::outcome_type outcome_ff, outcome_in;
   logic                 finished_ff, finished_in;

   logic                       ram_en;
   logic                       ram_we;
   logic [ewa_pkg::ADDR_W-1:0] ram_addr;
   logic [ewa_pkg::CELL_W-1:0] ram_wdata;
   logic [ewa_pkg::CELL_W-1:0] ram_rdata;

   logic [ewa_pkg::NCRD_W-1:0] nx;
   logic [ewa_pkg::NCRD_W-1:0] ny;
   logic                       nbr_ok;
   logic                       site_ok;
   logic [ewa_pkg::ADDR_W-1:0] site_addr;
   logic [ewa_pkg::ADDR_W-1:0] nbr_addr;
   ewa_pkg::cell_type          init_val;
   ewa_pkg::dec_in_type        din;
   ewa_pkg::dec_out_type       dout;

   ewa_ram #(
      .ADDR_W(ewa_pkg::ADDR_W),
      .DATA_W(ewa_pkg::CELL_W)
   ) u_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   ewa_decide u_decide (
      .item(item_ff),
      .cfg (cfg),
      .din (din),
      .dout(dout)
   );

   // Neighbor coordinates carry one extra bit so an east or north step never wraps.
   always_comb begin
      nx     = {1'b0, item_ff.site_x};
      ny     = {1'b0, item_ff.site_y};
      nbr_ok = 1'b0;
      unique case (ewa_pkg::dir_type'(item_ff.direction))
         ewa_pkg::DIR_EAST: begin
            nbr_ok = (32'(item_ff.site_x) + 1) < ewa_pkg::SIDE;
            nx     = {1'b0, item_ff.site_x} + ewa_pkg::NCRD_W'(1);
         end
         ewa_pkg::DIR_NORTH: begin
            nbr_ok = (32'(item_ff.site_y) + 1) < ewa_pkg::SIDE;
            ny     = {1'b0, item_ff.site_y} + ewa_pkg::NCRD_W'(1);
         end
         ewa_pkg::DIR_WEST: begin
            nbr_ok = (item_ff.site_x != '0);
            nx     = {1'b0, item_ff.site_x} - ewa_pkg::NCRD_W'(1);
         end
         ewa_pkg::DIR_SOUTH: begin
            nbr_ok = (item_ff.site_y != '0);
            ny     = {1'b0, item_ff.site_y} - ewa_pkg::NCRD_W'(1);
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end

   assign site_ok   = (32'(item_ff.site_x) < ewa_pkg::SIDE) &&
                      (32'(item_ff.site_y) < ewa_pkg::SIDE);
   assign site_addr = ewa_pkg::ADDR_W'(32'(item_ff.site_y) * ewa_pkg::SIDE +
                                       32'(item_ff.site_x));
   assign nbr_addr  = ewa_pkg::ADDR_W'(32'(ny) * ewa_pkg::SIDE + 32'(nx));

   always_comb begin
      if (32'(item_ff.site_x) == ewa_pkg::HALF_SIDE &&
          32'(item_ff.site_y) == ewa_pkg::HALF_SIDE) begin
         init_val = ewa_pkg::CELL_AGG;
      end else if (cfg.ghost_mode) begin
         init_val = ewa_pkg::CELL_GHOST;
      end else if (ewa_pkg::draw(item_ff.rand_fill_site, cfg.alive_thr)) begin
         init_val = ewa_pkg::CELL_LIVE;
      end else begin
         init_val = ewa_pkg::CELL_EMPTY;
      end
   end

   always_comb begin
      din.cs          = cs_ff;
      din.cn          = ewa_pkg::cell_type'(ram_rdata);
      din.site_border = (item_ff.site_x == '0) || (item_ff.site_y == '0) ||
                        (32'(item_ff.site_x) == ewa_pkg::SIDE - 1) ||
                        (32'(item_ff.site_y) == ewa_pkg::SIDE - 1);
      din.nbr_border  = (nx == '0) || (ny == '0) ||
                        (32'(nx) == ewa_pkg::SIDE - 1) || (32'(ny) == ewa_pkg::SIDE - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ewa_pkg::ST_IDLE;
         finished_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         finished_ff <= finished_in;
      end
      item_ff    <= item_in;
      cs_ff      <= cs_in;
      nbr_val_ff <= nbr_val_in;
      outcome_ff <= outcome_in;
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      cs_in       = cs_ff;
      nbr_val_in  = nbr_val_ff;
      outcome_in  = outcome_ff;
      finished_in = finished_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_en      = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = site_addr;
      ram_wdata   = '0;

      unique case (state_ff)
         ewa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_item;
               state_in = req_item.mode ? ewa_pkg::ST_RD_SITE : ewa_pkg::ST_INIT;
            end
         end
         ewa_pkg::ST_INIT: begin
            ram_en     = site_ok;
            ram_we     = site_ok;
            ram_wdata  = init_val;
            outcome_in = ewa_pkg::OUT_NONE;
            state_in   = ewa_pkg::ST_DONE;
         end
         ewa_pkg::ST_RD_SITE: begin
            if (finished_ff) begin
               outcome_in = ewa_pkg::OUT_IGNORED;
               state_in   = ewa_pkg::ST_DONE;
            end else if (!site_ok || !nbr_ok) begin
               outcome_in = ewa_pkg::OUT_NONE;
               state_in   = ewa_pkg::ST_DONE;
            end else begin
               ram_en   = 1'b1;
               state_in = ewa_pkg::ST_RD_NBR;
            end
         end
         ewa_pkg::ST_RD_NBR: begin
            cs_in    = ewa_pkg::cell_type'(ram_rdata);
            ram_en   = 1'b1;
            ram_addr = nbr_addr;
            state_in = ewa_pkg::ST_DECIDE;
         end
         ewa_pkg::ST_DECIDE: begin
            ram_en      = dout.wr_site;
            ram_we      = dout.wr_site;
            ram_wdata   = dout.site_val;
            nbr_val_in  = dout.nbr_val;
            outcome_in  = dout.outcome;
            finished_in = finished_ff | dout.set_finished;
            state_in    = dout.wr_nbr ? ewa_pkg::ST_WR_NBR : ewa_pkg::ST_DONE;
         end
         ewa_pkg::ST_WR_NBR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = nbr_addr;
            ram_wdata = nbr_val_ff;
            state_in  = ewa_pkg::ST_DONE;
         end
         ewa_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ewa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ewa_pkg::ST_IDLE;
         end
      endcase
   end

   assign res.outcome  = outcome_ff;
   assign res.run_over = finished_ff;

`ifndef SYNTHESIS
   // Lattice writes happen only in the init and write-back steps.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ewa_pkg::ST_INIT || state_ff == ewa_pkg::ST_DECIDE ||
                  state_ff == ewa_pkg::ST_WR_NBR))
      else $error("lattice write outside a write step");

   // Once the run is over it stays over until reset.
   assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("run_over dropped without reset");

   // An ignored update is reported only after the run is over.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && outcome_ff == ewa_pkg::OUT_IGNORED) |-> finished_ff)
      else $error("ignored outcome while run is live");

   // The second write-back follows the decision step directly.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ewa_pkg::ST_WR_NBR) |-> ($past(state_ff) == ewa_pkg::ST_DECIDE))
      else $error("neighbor write-back out of order");
`endif

endmodule
